/* rtl/core/cds_pkg.sv */
// ----------------------------------------------------------------------------
// cds_pkg
// Shared widths, constants, types and the segment decode helpers for the
// clock display scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

    localparam int unsigned FIELD_W  = 7;
    localparam int unsigned SEG_W    = 8;
    localparam int unsigned NUM_DIGS = 8;
    localparam int unsigned DIG_IDX_W = $clog2(NUM_DIGS);
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [CNT_W-1:0] BLINK_PERIOD_RST = 8'd250;
    localparam logic [CNT_W-1:0] PAGE_PERIOD_RST  = 8'd5;

    // register indexes, decoded from paddr[2]
    localparam logic REG_BLINK_PERIOD = 1'b0;
    localparam logic REG_PAGE_PERIOD  = 1'b1;

    localparam logic [SEG_W-1:0] SEG_DASH  = 8'hbf;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hff;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 7'd99;

    typedef struct packed {
        logic [FIELD_W-1:0] seconds;
        logic [FIELD_W-1:0] minutes;
        logic [FIELD_W-1:0] hours;
        logic [FIELD_W-1:0] day_of_month;
        logic [FIELD_W-1:0] month_number;
        logic [FIELD_W-1:0] year_in_century;
    } t_in_item;

    typedef struct packed {
        logic                 time_page;
        logic                 blink_flag;
        logic [DIG_IDX_W-1:0] digit_index;
    } t_view;

    // active-low seven-segment code of one decimal digit, dp never lit
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] dig);
        logic [SEG_W-1:0] seg;
        unique case (dig)
            4'd0:    seg = 8'hc0;
            4'd1:    seg = 8'hf9;
            4'd2:    seg = 8'ha4;
            4'd3:    seg = 8'hb0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hf8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // saturate to 99, tens digit; v*205>>11 is exact for v below 1029
    function automatic logic [3:0] tens_of(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] s;
        logic [15:0]        p;
        s = (v > FIELD_MAX) ? FIELD_MAX : v;
        p = 16'(s) * 16'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] units_of(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] s;
        logic [3:0]         t;
        logic [FIELD_W-1:0] r;
        s = (v > FIELD_MAX) ? FIELD_MAX : v;
        t = tens_of(v);
        r = s - FIELD_W'(t) * FIELD_W'(10);
        return r[3:0];
    endfunction

endpackage : cds_pkg

`default_nettype wire

/* rtl/core/cds_in_if.sv */
// ----------------------------------------------------------------------------
// cds_in_if
// Request channel carrying one scan tick with the current time and date.
// ----------------------------------------------------------------------------
`default_nettype none

interface cds_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] seconds;
    logic [6:0] minutes;
    logic [6:0] hours;
    logic [6:0] day_of_month;
    logic [6:0] month_number;
    logic [6:0] year_in_century;

    modport source (
        output valid, seconds, minutes, hours, day_of_month, month_number,
               year_in_century,
        input  ready
    );
    modport sink (
        input  valid, seconds, minutes, hours, day_of_month, month_number,
               year_in_century,
        output ready
    );
endinterface : cds_in_if

`default_nettype wire

/* rtl/core/cds_out_if.sv */
// ----------------------------------------------------------------------------
// cds_out_if
// Result channel: digit enable and segment pattern for one scan tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface cds_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_select;
    logic [7:0] segment_pattern;

    modport source (
        output valid, digit_select, segment_pattern,
        input  ready
    );
    modport sink (
        input  valid, digit_select, segment_pattern,
        output ready
    );
endinterface : cds_out_if

`default_nettype wire

/* rtl/core/clock_display_scanner_core.sv */
// ----------------------------------------------------------------------------
// clock_display_scanner_core
// Eight-digit multiplexed seven-segment clock and date display scanner.
// ----------------------------------------------------------------------------
// Each request is one scan tick and yields one result: a one-hot digit enable
// and the active-low segments for that digit. Requests pass through an input
// register and then a result register, so one tick is taken per clock while
// the receiver takes results; while a result is stalled, one more request can
// still enter the input register. The blink and page counters advance as a
// tick moves into the result register. Both period registers sit on the APB
// port (0x0 blink ticks, 0x4 page blinks).
// ----------------------------------------------------------------------------
`default_nettype none

module clock_display_scanner_core (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    cds_in_if.sink                           i_in,
    cds_out_if.source                        o_out,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [cds_pkg::PADDR_W-1:0]       paddr,
    input  wire [cds_pkg::PDATA_W-1:0]       pwdata,
    output logic [cds_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import cds_pkg::*;

    logic [CNT_W-1:0]     r_blink_period;
    logic [CNT_W-1:0]     r_page_period;
    logic [CNT_W-1:0]     r_tick_count,  n_tick_count;
    logic [CNT_W-1:0]     r_blink_count, n_blink_count;
    logic                 r_blink_flag,  n_blink_flag;
    logic                 r_time_page,   n_time_page;
    logic [DIG_IDX_W-1:0] r_digit_index;

    t_in_item             r_item;
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic [SEG_W-1:0]     r_seg;
    logic [NUM_DIGS-1:0]  r_dsel;

    logic                 advance;
    logic                 in_take;
    logic                 blink_evt;
    logic                 page_evt;
    logic [CNT_W-1:0]     tick_inc;
    logic [CNT_W-1:0]     blink_inc;
    t_view                view;
    logic [SEG_W-1:0]     seg;
    logic                 cfg_wr;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_period <= BLINK_PERIOD_RST;
            r_page_period  <= PAGE_PERIOD_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BLINK_PERIOD) begin
                r_blink_period <= pwdata[CNT_W-1:0];
            end else begin
                r_page_period <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BLINK_PERIOD: prdata = PDATA_W'(r_blink_period);
            REG_PAGE_PERIOD:  prdata = PDATA_W'(r_page_period);
            default:          prdata = '0;
        endcase
    end

    // ---- handshake ----
    assign advance    = r_in_valid & (~r_out_valid | o_out.ready);
    assign i_in.ready = ~r_in_valid | advance;
    assign in_take    = i_in.valid & i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.seconds         <= i_in.seconds;
            r_item.minutes         <= i_in.minutes;
            r_item.hours           <= i_in.hours;
            r_item.day_of_month    <= i_in.day_of_month;
            r_item.month_number    <= i_in.month_number;
            r_item.year_in_century <= i_in.year_in_century;
        end
    end

    // ---- blink and page counters, updated before the digit is shown ----
    assign tick_inc  = r_tick_count + 1'b1;
    assign blink_evt = (tick_inc >= r_blink_period);
    assign blink_inc = r_blink_count + 1'b1;
    assign page_evt  = blink_evt & (blink_inc >= r_page_period);

    always_comb begin
        n_tick_count  = blink_evt ? '0 : tick_inc;
        n_blink_flag  = r_blink_flag ^ blink_evt;
        n_time_page   = r_time_page ^ page_evt;
        n_blink_count = r_blink_count;
        if (blink_evt) begin
            n_blink_count = page_evt ? '0 : blink_inc;
        end
    end

    assign view.time_page   = n_time_page;
    assign view.blink_flag  = n_blink_flag;
    assign view.digit_index = r_digit_index;

    cds_seg_mux u_seg_mux (
        .i_item (r_item),
        .i_view (view),
        .o_seg  (seg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count  <= '0;
            r_blink_count <= '0;
            r_blink_flag  <= 1'b0;
            r_time_page   <= 1'b0;
            r_digit_index <= '0;
        end else if (advance) begin
            r_tick_count  <= n_tick_count;
            r_blink_count <= n_blink_count;
            r_blink_flag  <= n_blink_flag;
            r_time_page   <= n_time_page;
            r_digit_index <= r_digit_index + 1'b1;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_seg  <= seg;
            r_dsel <= NUM_DIGS'(1) << r_digit_index;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.digit_select    = r_dsel;
    assign o_out.segment_pattern = r_seg;

endmodule : clock_display_scanner_core

`default_nettype wire

/* rtl/core/cds_seg_mux.sv */
// ----------------------------------------------------------------------------
// cds_seg_mux
// Picks the segment pattern for the active digit from the time or date page.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_seg_mux (
    input  wire cds_pkg::t_in_item         i_item,
    input  wire cds_pkg::t_view            i_view,
    output logic [cds_pkg::SEG_W-1:0]      o_seg
);
    import cds_pkg::*;

    logic [SEG_W-1:0] sep;

    assign sep = i_view.blink_flag ? SEG_BLANK : SEG_DASH;

    always_comb begin
        if (i_view.time_page) begin
            // hh sep mm sep ss, digit 7 down to 0
            unique case (i_view.digit_index)
                3'd0:    o_seg = seg_of(units_of(i_item.seconds));
                3'd1:    o_seg = seg_of(tens_of(i_item.seconds));
                3'd2:    o_seg = sep;
                3'd3:    o_seg = seg_of(units_of(i_item.minutes));
                3'd4:    o_seg = seg_of(tens_of(i_item.minutes));
                3'd5:    o_seg = sep;
                3'd6:    o_seg = seg_of(units_of(i_item.hours));
                default: o_seg = seg_of(tens_of(i_item.hours));
            endcase
        end else begin
            // 20 yy mm dd
            unique case (i_view.digit_index)
                3'd0:    o_seg = seg_of(units_of(i_item.day_of_month));
                3'd1:    o_seg = seg_of(tens_of(i_item.day_of_month));
                3'd2:    o_seg = seg_of(units_of(i_item.month_number));
                3'd3:    o_seg = seg_of(tens_of(i_item.month_number));
                3'd4:    o_seg = seg_of(units_of(i_item.year_in_century));
                3'd5:    o_seg = seg_of(tens_of(i_item.year_in_century));
                3'd6:    o_seg = seg_of(4'd0);
                default: o_seg = seg_of(4'd2);
            endcase
        end
    end

endmodule : cds_seg_mux

`default_nettype wire

/* bench/clock_display_scanner_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clock_display_scanner_core_test
// Self-checking bench for the clock display scanner. Scan ticks go in through
// a queue-fed driver and results are checked by a monitor against a local
// scan predictor. The period registers are rewritten over the APB port
// between phases, with the block drained each time. Both handshakes idle at
// random, and one long receiver hold-off forces the input to stall.
// ----------------------------------------------------------------------------

module clock_display_scanner_core_test;

    import cds_pkg::*;

    typedef struct packed {
        logic [7:0] digit_select;
        logic [7:0] segment_pattern;
    } t_scan_out;

    localparam int LONG_HOLD_AT     = 250;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int RAND_PHASES      = 10;
    localparam int PHASE_TICKS      = 40;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    cds_in_if  in_ch();
    cds_out_if out_ch();

    clock_display_scanner_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of registers and scan state
    logic [7:0] blink_ticks = BLINK_PERIOD_RST;
    logic [7:0] page_blinks = PAGE_PERIOD_RST;
    logic [7:0] tick_cnt    = 8'd0;
    logic [7:0] blink_cnt   = 8'd0;
    logic       blink_on    = 1'b0;
    logic       show_time   = 1'b0;
    logic [2:0] dig_idx     = 3'd0;

    t_in_item  tick_queue[$];
    t_scan_out scan_expect[$];

    int  ticks_queued = 0;
    int  results_seen = 0;
    int  fail_cnt     = 0;
    bit  idle_on      = 1'b0;
    bit  req_taken    = 1'b0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;
    int  rx_hold      = 0;
    bit  hold_done    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [7:0] digit_seg(input int dig);
        case (dig)
            0:       return 8'hc0;
            1:       return 8'hf9;
            2:       return 8'ha4;
            3:       return 8'hb0;
            4:       return 8'h99;
            5:       return 8'h92;
            6:       return 8'h82;
            7:       return 8'hf8;
            8:       return 8'h80;
            default: return 8'h90;
        endcase
    endfunction

    function automatic int clamp99(input logic [6:0] v);
        return (v > 7'd99) ? 99 : int'(v);
    endfunction

    function automatic logic [7:0] lo_seg(input logic [6:0] v);
        return digit_seg(clamp99(v) % 10);
    endfunction

    function automatic logic [7:0] hi_seg(input logic [6:0] v);
        return digit_seg(clamp99(v) / 10);
    endfunction

    // counters move first, then the current digit is decoded
    function automatic t_scan_out predict_scan(input t_in_item t);
        t_scan_out  r;
        logic [7:0] sep;
        logic [2:0] d;
        d = dig_idx;
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= blink_ticks) begin
            tick_cnt  = 8'd0;
            blink_on  = ~blink_on;
            blink_cnt = blink_cnt + 8'd1;
            if (blink_cnt >= page_blinks) begin
                blink_cnt = 8'd0;
                show_time = ~show_time;
            end
        end
        sep = blink_on ? SEG_BLANK : SEG_DASH;
        if (show_time) begin
            case (d)
                3'd0:    r.segment_pattern = lo_seg(t.seconds);
                3'd1:    r.segment_pattern = hi_seg(t.seconds);
                3'd2:    r.segment_pattern = sep;
                3'd3:    r.segment_pattern = lo_seg(t.minutes);
                3'd4:    r.segment_pattern = hi_seg(t.minutes);
                3'd5:    r.segment_pattern = sep;
                3'd6:    r.segment_pattern = lo_seg(t.hours);
                default: r.segment_pattern = hi_seg(t.hours);
            endcase
        end else begin
            case (d)
                3'd0:    r.segment_pattern = lo_seg(t.day_of_month);
                3'd1:    r.segment_pattern = hi_seg(t.day_of_month);
                3'd2:    r.segment_pattern = lo_seg(t.month_number);
                3'd3:    r.segment_pattern = hi_seg(t.month_number);
                3'd4:    r.segment_pattern = lo_seg(t.year_in_century);
                3'd5:    r.segment_pattern = hi_seg(t.year_in_century);
                3'd6:    r.segment_pattern = digit_seg(0);
                default: r.segment_pattern = digit_seg(2);
            endcase
        end
        r.digit_select = 8'd1 << d;
        dig_idx = d + 3'd1;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [6:0] rnd_field();
        if ($urandom_range(0, 9) < 8)
            return 7'($urandom_range(0, 99));
        else
            return 7'($urandom_range(0, 127));
    endfunction

    // request driver
    always @(negedge i_clk) begin : tick_driver
        t_in_item nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!(in_ch.valid && !req_taken)) begin
            if (tx_gap > 0) begin
                in_ch.valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end else if (tick_queue.size() > 0) begin
                nxt = tick_queue.pop_front();
                in_ch.seconds         <= nxt.seconds;
                in_ch.minutes         <= nxt.minutes;
                in_ch.hours           <= nxt.hours;
                in_ch.day_of_month    <= nxt.day_of_month;
                in_ch.month_number    <= nxt.month_number;
                in_ch.year_in_century <= nxt.year_in_century;
                in_ch.valid <= 1'b1;
                tx_gap <= idle_on ? pick_gap() : 0;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            out_ch.ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
            out_ch.ready <= 1'b0;
            rx_hold <= LONG_HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (rx_gap > 0) begin
            out_ch.ready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else begin
            out_ch.ready <= 1'b1;
            rx_gap <= idle_on ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin : scan_monitor
        t_in_item  t;
        t_scan_out want;
        req_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                t.seconds         = in_ch.seconds;
                t.minutes         = in_ch.minutes;
                t.hours           = in_ch.hours;
                t.day_of_month    = in_ch.day_of_month;
                t.month_number    = in_ch.month_number;
                t.year_in_century = in_ch.year_in_century;
                scan_expect.push_back(predict_scan(t));
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen <= results_seen + 1;
                if (scan_expect.size() == 0) begin
                    $error("unexpected result: digit_select %h segment_pattern %h",
                           out_ch.digit_select, out_ch.segment_pattern);
                    fail_cnt++;
                end else begin
                    want = scan_expect.pop_front();
                    if (out_ch.digit_select !== want.digit_select) begin
                        $error("digit_select: expected %h, got %h",
                               want.digit_select, out_ch.digit_select);
                        fail_cnt++;
                    end
                    if (out_ch.segment_pattern !== want.segment_pattern) begin
                        $error("segment_pattern: expected %h, got %h",
                               want.segment_pattern, out_ch.segment_pattern);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    task automatic queue_tick(input t_in_item t);
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        wait (results_seen >= ticks_queued);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(input logic [PADDR_W-1:0] addr, input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== PDATA_W'(val)) begin
            $error("prdata at %h: expected %h, got %h", addr, PDATA_W'(val), prdata);
            fail_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_periods(input logic [7:0] blink, input logic [7:0] page);
        logic [PADDR_W-1:0] blink_addr;
        logic [PADDR_W-1:0] page_addr;
        blink_addr = {REG_BLINK_PERIOD, 2'b00};
        page_addr  = {REG_PAGE_PERIOD, 2'b00};
        apb_write(blink_addr, blink);
        apb_write(page_addr, page);
        blink_ticks = blink;
        page_blinks = page;
        apb_check(blink_addr, blink);
        apb_check(page_addr, page);
    endtask

    // eight ticks whose fields walk through the extremes, shifted per field
    task automatic queue_edge_ticks();
        logic [6:0] v [8];
        t_in_item   t;
        v = '{7'd0, 7'd127, 7'd99, 7'd100, 7'd9, 7'd10, 7'd59, 7'd45};
        for (int i = 0; i < 8; i++) begin
            t.seconds         = v[i % 8];
            t.minutes         = v[(i + 1) % 8];
            t.hours           = v[(i + 2) % 8];
            t.day_of_month    = v[(i + 3) % 8];
            t.month_number    = v[(i + 4) % 8];
            t.year_in_century = v[(i + 5) % 8];
            queue_tick(t);
        end
    endtask

    initial begin : stimulus
        logic [7:0] blink_set [RAND_PHASES];
        logic [7:0] page_set  [RAND_PHASES];
        t_in_item   t;
        blink_set = '{8'd3, 8'd1, 8'd0, 8'd255, 8'd5, 8'd2, 8'd0, 8'd1, 8'd4, 8'd2};
        page_set  = '{8'd2, 8'd3, 8'd1, 8'd1, 8'd255, 8'd1, 8'd0, 8'd255, 8'd2, 8'd7};

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.seconds = '0;
        in_ch.minutes = '0;
        in_ch.hours = '0;
        in_ch.day_of_month = '0;
        in_ch.month_number = '0;
        in_ch.year_in_century = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, date page
        apb_check({REG_BLINK_PERIOD, 2'b00}, BLINK_PERIOD_RST);
        apb_check({REG_PAGE_PERIOD, 2'b00}, PAGE_PERIOD_RST);
        queue_edge_ticks();
        wait_drained();

        // blink and page flip on every tick
        set_periods(8'd1, 8'd1);
        queue_edge_ticks();
        wait_drained();

        // zero periods: every tick fires both events
        set_periods(8'd0, 8'd0);
        queue_edge_ticks();
        wait_drained();

        // random phases; a lowered period finds the counters above it
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_periods(blink_set[p], page_set[p]);
            idle_on = (p % 3 != 2);
            for (int i = 0; i < PHASE_TICKS; i++) begin
                t.seconds         = rnd_field();
                t.minutes         = rnd_field();
                t.hours           = rnd_field();
                t.day_of_month    = rnd_field();
                t.month_number    = rnd_field();
                t.year_in_century = rnd_field();
                queue_tick(t);
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* clock_display_scanner_core.f */
rtl/core/cds_pkg.sv
rtl/core/cds_in_if.sv
rtl/core/cds_out_if.sv
rtl/core/cds_seg_mux.sv
rtl/core/clock_display_scanner_core.sv
bench/clock_display_scanner_core_test.sv
